// ===== hdl/pat_pkg.sv =====
// Shared types and codes for the positional array table.
`default_nettype none

package pat_pkg;

   localparam int DATA_W = 32;

   // Command codes carried on the request side.
   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_INSERT = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_SEARCH = 3'd3;
   localparam logic [2:0] FUNC_FILL   = 3'd4;
   localparam logic [2:0] FUNC_CLEAR  = 3'd5;

   // Status codes returned on the response side.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_BAD_POS   = 3'd2;
   localparam logic [2:0] STATUS_EMPTY     = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } pat_state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_FILL
   } pat_cell_op_type;

   typedef struct packed {
      pat_cell_op_type    op;
      logic               capture;
      logic               search;
      logic [DATA_W-1:0]  value;
   } pat_cell_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/pat_cell.sv =====
// One entry of the table: holds a value, shifts with its neighbors, flags a hit.
`default_nettype none

module pat_cell #(
   parameter int DEPTH = 16,
   parameter int IDX   = 0
) (
   input  wire                               clock,
   input  wire pat_pkg::pat_cell_ctl_type    ctl,
   input  wire [$clog2(DEPTH)-1:0]           k,
   input  wire [$clog2(DEPTH+1)-1:0]         cnt,
   input  wire [pat_pkg::DATA_W-1:0]         left_data,
   input  wire [pat_pkg::DATA_W-1:0]         right_data,
   output logic [pat_pkg::DATA_W-1:0]        data_out,
   output logic                              hit_out
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [IW-1:0] MY_IDX = IW'(IDX);
   localparam logic [CW-1:0] MY_CNT = CW'(IDX);

   logic [pat_pkg::DATA_W-1:0] data_ff, data_in;
   logic                       hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         pat_pkg::CELL_INSERT: begin
            if (MY_IDX > k) begin
               data_in = left_data;
            end else if (MY_IDX == k) begin
               data_in = ctl.value;
            end
         end
         pat_pkg::CELL_REMOVE: begin
            if (MY_IDX >= k) begin
               data_in = right_data;
            end
         end
         pat_pkg::CELL_FILL: data_in = ctl.value;
         default: data_in = data_ff;
      endcase
   end

   // A search hit counts only inside the used part of the list; otherwise the
   // flag marks the cell addressed by k.
   always_comb begin
      hit_in = hit_ff;
      if (ctl.capture) begin
         if (ctl.search) begin
            hit_in = (data_ff == ctl.value) && (MY_CNT < cnt);
         end else begin
            hit_in = (MY_IDX == k);
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data_out = data_ff;
   assign hit_out  = hit_ff;

endmodule

`default_nettype wire

// ===== hdl/positional_array_table.sv =====
// Top level of the positional array table: command decode, sequencing and the cell row.
//
// The block keeps a packed list of signed 32-bit values, one per cell of a row of
// DEPTH cells. A command transaction enters on the req_ channel (command code in
// req_tuser, position and value in req_tdata) and produces exactly one response
// transaction on the rsp_ channel carrying ok, status, the removed value, the found
// position and the entry count after the command.
// An accepted command spends a decode step, where every cell also flags a search
// match or the addressed entry, and a final step in which the cells shift, load or
// fill together and the response register is written. A new command is taken only
// after the block has returned to idle from that final step, so one command is done
// before the next is accepted; the three-step sequencer around the cell row sets
// this, independent of DEPTH.
// A response that waits in the output register does not block decode of the next
// command; the row is only updated once the response register is free, so a
// stalled receiver holds the block in its final step with nothing lost.
// The user must write the capacity register through csr_ only while the block is
// idle, which the block does not check. Zero means the list may use all DEPTH cells.
// Reset empties the list and clears capacity; cell contents are not cleared, and
// no command ever reads a cell beyond the entry count.
`default_nettype none

module positional_array_table #(
   parameter int DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // position[5:0], value[37:6], zero pad[39:38]
   input  wire  [2:0]  req_tuser,  // func[2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,  // ok[0], status[3:1], removed_value[35:4],
                                   // found_position[40:36], entry_count[45:41], pad
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [4:0]  csr_data    // capacity[4:0]
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int SW = (CW + 2 > 7) ? CW + 2 : 7;
   localparam int DW = pat_pkg::DATA_W;
   localparam logic signed [SW-1:0] ONE_S = 1;

   pat_pkg::pat_state_type state_ff, state_in;

   // Command held for the duration of its processing.
   logic [2:0]               cmd_func_ff;
   logic signed [5:0]        cmd_pos_ff;
   logic [DW-1:0]            cmd_value_ff;

   logic [CW-1:0]            count_ff, count_in;
   logic [4:0]               capacity_ff;

   // Decision taken in the decode step and applied in the final step.
   pat_pkg::pat_cell_op_type dec_op_ff, dec_op_in;
   logic [IW-1:0]            dec_k_ff, dec_k_in;
   logic                     dec_ok_ff, dec_ok_in;
   logic [2:0]               dec_status_ff, dec_status_in;
   logic [CW-1:0]            dec_count_ff, dec_count_in;
   logic                     dec_search_ff, dec_search_in;
   logic                     dec_remove_ff, dec_remove_in;

   logic                     rsp_valid_ff;
   logic [47:0]              rsp_tdata_ff, rsp_tdata_in;

   logic                     req_fire, finish_fire;

   // Decode arithmetic on signed positions.
   logic signed [SW-1:0]     cnt_s, pos_s, pos_n;
   logic [SW-1:0]            cap_w, limit_w;
   logic                     full, ins_bad, rem_bad;
   logic [IW-1:0]            k_pos;

   // Cell row.
   pat_pkg::pat_cell_ctl_type cell_ctl;
   logic [IW-1:0]            cell_k;
   logic [DW-1:0]            cell_data [DEPTH];
   logic [DEPTH-1:0]         cell_hit;

   // Response assembly.
   logic                     any_hit;
   logic [IW-1:0]            first_idx;
   logic [DW-1:0]            removed_or;
   logic                     out_ok;
   logic [2:0]               out_status;
   logic [DW-1:0]            out_removed;
   logic [CW-1:0]            out_found;

   assign req_tready  = (state_ff == pat_pkg::ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign finish_fire = (state_ff == pat_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_tdata_ff;

   // Sequencer: idle, decode and match capture, then update and respond.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pat_pkg::ST_IDLE:   if (req_fire) state_in = pat_pkg::ST_EXEC;
         pat_pkg::ST_EXEC:   state_in = pat_pkg::ST_FINISH;
         pat_pkg::ST_FINISH: if (finish_fire) state_in = pat_pkg::ST_IDLE;
         default:            state_in = pat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_func_ff  <= req_tuser;
         cmd_pos_ff   <= signed'(req_tdata[5:0]);
         cmd_value_ff <= req_tdata[37:6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // Negative positions count back from the end: p stands for p + count + 1.
   // A capacity of zero, or one beyond the row, means the whole row.
   always_comb begin
      cnt_s   = signed'(SW'(count_ff));
      pos_s   = SW'(cmd_pos_ff);
      cap_w   = SW'(capacity_ff);
      limit_w = (capacity_ff == '0 || cap_w > SW'(DEPTH)) ? SW'(DEPTH) : cap_w;
      full    = SW'(count_ff) >= limit_w;
      pos_n   = (pos_s < 0 && pos_s >= -cnt_s) ? pos_s + cnt_s + ONE_S : pos_s;
      ins_bad = (pos_n < ONE_S) || (pos_n > cnt_s + ONE_S);
      rem_bad = (pos_n < ONE_S) || (pos_n > cnt_s);
      k_pos   = IW'(pos_n - ONE_S);
   end

   always_comb begin
      dec_op_in     = pat_pkg::CELL_HOLD;
      dec_k_in      = k_pos;
      dec_ok_in     = 1'b0;
      dec_status_in = pat_pkg::STATUS_OK;
      dec_count_in  = count_ff;
      dec_search_in = 1'b0;
      dec_remove_in = 1'b0;
      case (cmd_func_ff)
         pat_pkg::FUNC_APPEND: begin
            if (full) begin
               dec_status_in = pat_pkg::STATUS_FULL;
            end else begin
               dec_op_in    = pat_pkg::CELL_INSERT;
               dec_k_in     = IW'(count_ff);
               dec_ok_in    = 1'b1;
               dec_count_in = count_ff + CW'(1);
            end
         end
         pat_pkg::FUNC_INSERT: begin
            // The position is checked ahead of the full test.
            if (ins_bad) begin
               dec_status_in = pat_pkg::STATUS_BAD_POS;
            end else if (full) begin
               dec_status_in = pat_pkg::STATUS_FULL;
            end else begin
               dec_op_in    = pat_pkg::CELL_INSERT;
               dec_ok_in    = 1'b1;
               dec_count_in = count_ff + CW'(1);
            end
         end
         pat_pkg::FUNC_REMOVE: begin
            if (count_ff == '0) begin
               dec_status_in = pat_pkg::STATUS_EMPTY;
            end else if (rem_bad) begin
               dec_status_in = pat_pkg::STATUS_BAD_POS;
            end else begin
               dec_op_in     = pat_pkg::CELL_REMOVE;
               dec_ok_in     = 1'b1;
               dec_remove_in = 1'b1;
               dec_count_in  = count_ff - CW'(1);
            end
         end
         pat_pkg::FUNC_SEARCH: begin
            dec_search_in = 1'b1;
            dec_status_in = pat_pkg::STATUS_NOT_FOUND;
         end
         pat_pkg::FUNC_FILL: begin
            // Cells past the count are filled too; they are never read.
            dec_op_in = pat_pkg::CELL_FILL;
            dec_ok_in = 1'b1;
         end
         pat_pkg::FUNC_CLEAR: begin
            dec_ok_in    = 1'b1;
            dec_count_in = '0;
         end
         default: dec_status_in = pat_pkg::STATUS_BAD_POS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == pat_pkg::ST_EXEC) begin
         dec_op_ff     <= dec_op_in;
         dec_k_ff      <= dec_k_in;
         dec_ok_ff     <= dec_ok_in;
         dec_status_ff <= dec_status_in;
         dec_count_ff  <= dec_count_in;
         dec_search_ff <= dec_search_in;
         dec_remove_ff <= dec_remove_in;
      end
   end

   // During decode every cell latches its hit flag; the row itself only moves
   // when the response register can take the result.
   always_comb begin
      cell_ctl.value   = cmd_value_ff;
      cell_ctl.search  = dec_search_in;
      cell_ctl.capture = (state_ff == pat_pkg::ST_EXEC);
      cell_ctl.op      = finish_fire ? dec_op_ff : pat_pkg::CELL_HOLD;
      cell_k           = (state_ff == pat_pkg::ST_EXEC) ? dec_k_in : dec_k_ff;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DW-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      pat_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .k          (cell_k),
         .cnt        (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i]),
         .hit_out    (cell_hit[i])
      );
   end

   // Lowest hit wins for search; for remove exactly one cell is flagged and
   // its value is picked out by an AND-OR over the row.
   always_comb begin
      any_hit    = |cell_hit;
      first_idx  = '0;
      removed_or = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            first_idx = IW'(i);
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         removed_or = removed_or | (cell_data[i] & {DW{cell_hit[i]}});
      end
   end

   always_comb begin
      out_ok      = dec_search_ff ? any_hit : dec_ok_ff;
      out_status  = dec_status_ff;
      if (dec_search_ff && any_hit) begin
         out_status = pat_pkg::STATUS_OK;
      end
      out_removed = dec_remove_ff ? removed_or : '0;
      out_found   = (dec_search_ff && any_hit) ? CW'(first_idx) + CW'(1) : '0;
      rsp_tdata_in = {2'b00, 5'(dec_count_ff), 5'(out_found), out_removed, out_status,
                      out_ok};
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (finish_fire) begin
         count_in = dec_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond row depth");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == pat_pkg::ST_EXEC)
      else $error("accepted command did not enter decode");

   a_remove_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pat_pkg::ST_FINISH && dec_remove_ff) |-> $onehot(cell_hit))
      else $error("remove does not address exactly one cell");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tdata_ff[0] == (rsp_tdata_ff[3:1] == pat_pkg::STATUS_OK)))
      else $error("ok flag disagrees with status");
`endif

endmodule

`default_nettype wire
